// ----- rtl/core/wrsa_pkg.sv -----
// ---------------------------------------------------------------------------
// Weighted residual shortcut add package
// Shared constants, register codes and the exponent tables.
// ---------------------------------------------------------------------------
package wrsa_pkg;

  localparam int MAX_ADDED      = 4;
  localparam int NUM_SLOTS      = MAX_ADDED + 1;
  localparam int MAX_CHANNELS   = 1024;
  localparam int CH_W           = $clog2(MAX_CHANNELS);
  localparam int DATA_WIDTH_DEF = 16;
  localparam int EPS_Q16        = 7;

  typedef enum logic {
    OP_ELEMENT = 1'b0,
    OP_WEIGHT  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_NUM_ADDED   = 2'd0,
    CFG_WEIGHT_MODE = 2'd1,
    CFG_NORM        = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    WM_NONE    = 2'd0,
    WM_FEATURE = 2'd1,
    WM_CHANNEL = 2'd2
  } weight_mode_t;

  typedef enum logic [1:0] {
    NORM_RAW     = 2'd0,
    NORM_RELU    = 2'd1,
    NORM_SOFTMAX = 2'd2
  } norm_t;

  // exp(-x) for the integer part of x, Q.16.
  function automatic logic [16:0] exp_a(input logic [3:0] idx);
    logic [16:0] r;
    unique case (idx)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd24109;
      4'd2:  r = 17'd8869;
      4'd3:  r = 17'd3263;
      4'd4:  r = 17'd1200;
      4'd5:  r = 17'd442;
      4'd6:  r = 17'd162;
      4'd7:  r = 17'd60;
      4'd8:  r = 17'd22;
      4'd9:  r = 17'd8;
      4'd10: r = 17'd3;
      4'd11: r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // exp(-x) for x in sixteenths, Q.16.
  function automatic logic [16:0] exp_b(input logic [3:0] idx);
    logic [16:0] r;
    unique case (idx)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd61565;
      4'd2:  r = 17'd57835;
      4'd3:  r = 17'd54331;
      4'd4:  r = 17'd51040;
      4'd5:  r = 17'd47947;
      4'd6:  r = 17'd45042;
      4'd7:  r = 17'd42313;
      4'd8:  r = 17'd39750;
      4'd9:  r = 17'd37341;
      4'd10: r = 17'd35079;
      4'd11: r = 17'd32954;
      4'd12: r = 17'd30957;
      4'd13: r = 17'd29081;
      4'd14: r = 17'd27319;
      4'd15: r = 17'd25664;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // exp(-x) for x in 256ths, Q.16.
  function automatic logic [16:0] exp_c(input logic [3:0] idx);
    logic [16:0] r;
    unique case (idx)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd65280;
      4'd2:  r = 17'd65026;
      4'd3:  r = 17'd64772;
      4'd4:  r = 17'd64520;
      4'd5:  r = 17'd64268;
      4'd6:  r = 17'd64018;
      4'd7:  r = 17'd63768;
      4'd8:  r = 17'd63520;
      4'd9:  r = 17'd63272;
      4'd10: r = 17'd63025;
      4'd11: r = 17'd62780;
      4'd12: r = 17'd62535;
      4'd13: r = 17'd62291;
      4'd14: r = 17'd62048;
      4'd15: r = 17'd61806;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/weighted_residual_shortcut_add.sv -----
// ---------------------------------------------------------------------------
// Weighted residual shortcut add
// Forward pass of a weighted shortcut: own value plus weighted added values.
// ---------------------------------------------------------------------------
// The block takes one request per cycle while its output is not stalled and
// returns a result for each element request; weight writes give no result.
// The pipeline has 27 stages, most of which are the 17-stage restoring
// divider that normalizes the weights (one quotient bit per stage, five lanes
// side by side). The whole pipeline advances together, so a stalled output
// holds every stage. Weights live in five memories, one per slot, each 1024
// entries deep; entries are undefined until written.
module weighted_residual_shortcut_add
  import wrsa_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         operation,
  input  logic [9:0]                   channel,
  input  logic [2:0]                   weight_slot,
  input  logic signed [15:0]           weight_value,
  input  logic signed [DATA_WIDTH-1:0] own_value,
  input  logic signed [DATA_WIDTH-1:0] added_0,
  input  logic signed [DATA_WIDTH-1:0] added_1,
  input  logic signed [DATA_WIDTH-1:0] added_2,
  input  logic signed [DATA_WIDTH-1:0] added_3,
  input  logic [3:0]                   added_present,
  input  logic                         last_element,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] result_value,
  output logic                         saturated,
  output logic                         last_element_res,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [2:0]                   cfg_data
);

  localparam int NST  = 27;
  localparam int DIV0 = 6;
  localparam int DIVN = DIV0 + 17;
  localparam int EW   = 22;
  localparam int PW   = DATA_WIDTH + EW;
  localparam int AW   = PW + 3;
  localparam int QW   = AW - 16;
  localparam logic signed [QW-1:0] QHI = {{(QW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [QW-1:0] QLO = ~QHI;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]     own;
    logic [3:0][DATA_WIDTH-1:0]       added;
    logic [3:0]                       present;
    logic                             last;
    logic [2:0]                       n;
    logic [NUM_SLOTS-1:0][15:0]       w;
  } pay_t;

  // Configuration.
  logic [2:0] num_added;
  logic [1:0] weight_mode;
  logic [1:0] normalization;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_added     <= 3'd1;
      weight_mode   <= WM_NONE;
      normalization <= NORM_RAW;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NUM_ADDED:   num_added     <= cfg_data;
        CFG_WEIGHT_MODE: weight_mode   <= cfg_data[1:0];
        CFG_NORM:        normalization <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic use_w, use_norm;
  assign use_w    = (weight_mode == WM_FEATURE) || (weight_mode == WM_CHANNEL);
  assign use_norm = (normalization == NORM_RELU) || (normalization == NORM_SOFTMAX);

  // Pipeline control.
  logic          adv;
  logic          acc_in;
  logic [NST:1]  vld;
  pay_t          pay [1:NST-1];

  assign adv      = !vld[NST] || out_ready;
  assign in_ready = adv;
  assign acc_in   = in_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-1:1], in_valid && (operation == OP_ELEMENT)};
    end
  end
  assign out_valid = vld[NST];

  // Weight memories, one per slot.
  logic [CH_W-1:0] group;
  logic [15:0]     rd_w [NUM_SLOTS];

  assign group = (weight_mode == WM_CHANNEL) ? channel[CH_W-1:0] : '0;

  for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_mem
    logic [15:0] mem [0:MAX_CHANNELS-1];
    logic [15:0] rdq;
    always_ff @(posedge clk) begin
      if (acc_in && (operation == OP_WEIGHT) && (weight_slot == 3'(s))) begin
        mem[channel[CH_W-1:0]] <= weight_value;
      end
      if (adv) begin
        rdq <= mem[group];
      end
    end
    assign rd_w[s] = rdq;
  end

  // Stage 1: capture the element.
  logic [2:0] n_lim;
  assign n_lim = (num_added > 3'(MAX_ADDED)) ? 3'(MAX_ADDED) : num_added;

  always_ff @(posedge clk) begin
    if (adv) begin
      pay[1].own     <= own_value;
      pay[1].added   <= {added_3, added_2, added_1, added_0};
      pay[1].present <= added_present;
      pay[1].last    <= last_element;
      pay[1].n       <= n_lim;
      pay[1].w       <= '0;
    end
  end

  // Stage 2: weights arrive, largest weight among the used slots.
  logic signed [15:0] mx_c, mx2;
  pay_t               pay2_c;

  always_comb begin
    mx_c = $signed(rd_w[0]);
    for (int i = 1; i < NUM_SLOTS; i++) begin
      if ((3'(i) <= pay[1].n) && ($signed(rd_w[i]) > mx_c)) mx_c = $signed(rd_w[i]);
    end
  end

  always_comb begin
    pay2_c = pay[1];
    for (int i = 0; i < NUM_SLOTS; i++) pay2_c.w[i] = rd_w[i];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pay[2] <= pay2_c;
      mx2    <= mx_c;
    end
  end

  for (genvar k = 3; k < NST; k++) begin : g_pay
    always_ff @(posedge clk) begin
      if (adv) pay[k] <= pay[k-1];
    end
  end

  // Stage 3: distance from the maximum, first exponent product, ReLU value.
  logic [33:0] ab3  [NUM_SLOTS];
  logic [3:0]  dlo3 [NUM_SLOTS];
  logic [19:0] rel3 [NUM_SLOTS];
  logic [19:0] rel4 [NUM_SLOTS];
  logic [33:0] abc4 [NUM_SLOTS];
  logic [19:0] v5   [NUM_SLOTS];

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_exp
    logic signed [16:0] diff;
    logic [15:0]        d;
    logic [33:0]        ab_r, abc_r;
    assign diff  = 17'(mx2) - 17'($signed(pay[2].w[i]));
    assign d     = diff[15:0];
    assign ab_r  = ab3[i] + 34'd32768;
    assign abc_r = abc4[i] + 34'd32768;

    always_ff @(posedge clk) begin
      if (adv) begin
        ab3[i]  <= 34'(exp_a(d[15:12])) * 34'(exp_b(d[11:8]));
        dlo3[i] <= d[7:4];
        rel3[i] <= ($signed(pay[2].w[i]) > 16'sd0) ? {pay[2].w[i], 4'b0000} : '0;
        // Stage 4.
        abc4[i] <= 34'(ab_r[32:16]) * 34'(exp_c(dlo3[i]));
        rel4[i] <= rel3[i];
        // Stage 5.
        v5[i]   <= (normalization == NORM_SOFTMAX) ? {3'b000, abc_r[32:16]} : rel4[i];
      end
    end
  end

  // Stage 6: normalizer sum and divider set-up. The quotient is
  // round(v * 65536 / S), done as (2v*65536 + S) / 2S.
  logic [21:0] s_c;
  logic [22:0] drem [DIV0:DIVN][NUM_SLOTS];
  logic [16:0] dlow [DIV0:DIVN][NUM_SLOTS];
  logic [16:0] dquo [DIV0:DIVN][NUM_SLOTS];
  logic [22:0] dden [DIV0:DIVN];

  always_comb begin
    s_c = 22'(EPS_Q16);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (3'(i) <= pay[5].n) s_c = s_c + 22'(v5[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dden[DIV0] <= {s_c, 1'b0};
      for (int i = 0; i < NUM_SLOTS; i++) begin
        drem[DIV0][i] <= 23'(v5[i]) + 23'(s_c[21:17]);
        dlow[DIV0][i] <= s_c[16:0];
        dquo[DIV0][i] <= '0;
      end
    end
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar k = DIV0 + 1; k <= DIVN; k++) begin : g_div
    logic [22:0] rn [NUM_SLOTS];
    logic        qb [NUM_SLOTS];
    always_comb begin
      logic [23:0] trial;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        trial = {drem[k-1][i], dlow[k-1][i][16]};
        if (trial >= {1'b0, dden[k-1]}) begin
          rn[i] = 23'(trial - {1'b0, dden[k-1]});
          qb[i] = 1'b1;
        end else begin
          rn[i] = trial[22:0];
          qb[i] = 1'b0;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dden[k] <= dden[k-1];
        for (int i = 0; i < NUM_SLOTS; i++) begin
          drem[k][i] <= rn[i];
          dlow[k][i] <= {dlow[k-1][i][15:0], 1'b0};
          dquo[k][i] <= {dquo[k-1][i][15:0], qb[i]};
        end
      end
    end
  end

  // Stage 24: effective weights. Stage 25: products. Stage 26: sum.
  logic signed [EW-1:0] eff24  [NUM_SLOTS];
  logic signed [PW-1:0] prod25 [NUM_SLOTS];
  logic signed [AW-1:0] acc_c, acc26;
  localparam int PI = DIVN;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!use_w) begin
          eff24[i] <= EW'(65536);
        end else if (use_norm) begin
          eff24[i] <= {5'b00000, dquo[DIVN][i]};
        end else begin
          eff24[i] <= {{2{pay[PI].w[i][15]}}, pay[PI].w[i], 4'b0000};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod25[0] <= PW'($signed(pay[PI+1].own)) * PW'(eff24[0]);
      for (int i = 1; i < NUM_SLOTS; i++) begin
        if ((3'(i) <= pay[PI+1].n) && pay[PI+1].present[i-1]) begin
          prod25[i] <= PW'($signed(pay[PI+1].added[i-1])) * PW'(eff24[i]);
        end else begin
          prod25[i] <= '0;
        end
      end
    end
  end

  always_comb begin
    acc_c = '0;
    for (int i = 0; i < NUM_SLOTS; i++) acc_c = acc_c + AW'(prod25[i]);
  end

  always_ff @(posedge clk) begin
    if (adv) acc26 <= acc_c;
  end

  // Stage 27: round half up to Q8.8 and saturate.
  logic signed [AW-1:0] t_c;
  logic signed [QW-1:0] q_c;
  assign t_c = acc26 + AW'(32768);
  assign q_c = t_c[AW-1:16];

  always_ff @(posedge clk) begin
    if (adv) begin
      last_element_res <= pay[NST-1].last;
      if (q_c > QHI) begin
        result_value <= QHI[DATA_WIDTH-1:0];
        saturated    <= 1'b1;
      end else if (q_c < QLO) begin
        result_value <= QLO[DATA_WIDTH-1:0];
        saturated    <= 1'b1;
      end else begin
        result_value <= q_c[DATA_WIDTH-1:0];
        saturated    <= 1'b0;
      end
    end
  end

  // A clipped result sits exactly at one end of the range.
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      result_value == QHI[DATA_WIDTH-1:0] || result_value == QLO[DATA_WIDTH-1:0])
    else $error("saturated result not at a range limit");

  a_elem_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == OP_ELEMENT |=> vld[1])
    else $error("accepted element request did not enter the pipeline");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == OP_WEIGHT |=> !vld[1])
    else $error("weight write entered the result pipeline");

  // The own weight is always part of the normalizer, so its share is at most one.
  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    vld[DIVN] && use_w && use_norm |-> dquo[DIVN][0] <= 17'd65536)
    else $error("normalized weight above one");

endmodule
